// File: hdl/pfu_pkg.sv
// Shared constants, register codes and types of the particle flow update unit.
package pfu_pkg;

	localparam int MAX_DOTS = 32;
	localparam int IDX_W    = $clog2(MAX_DOTS);
	localparam int CNT_W    = $clog2(MAX_DOTS + 1);

	localparam int POS_W    = 24;
	localparam int VEL_W    = 16;
	localparam int VELY_W   = 24;
	localparam int FALL_W   = 9;
	localparam int DELAY_W  = 10;
	localparam int TIME_W   = 16;
	localparam int BOX_W    = 16;
	localparam int LIM_W    = POS_W + 1;
	localparam int LIVE_W   = 6;
	localparam int SLOT_W   = 5;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_X_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_X_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_Y_LOW  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_Y_HIGH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_Z_LOW  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_Z_HIGH = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FOLLOW     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DOTS       = 3'd7;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	// One particle slot as held in the slot memory.
	typedef struct packed {
		logic [POS_W-1:0]   pos_x;
		logic [POS_W-1:0]   pos_y;
		logic [POS_W-1:0]   pos_z;
		logic [VEL_W-1:0]   vel_x;
		logic [VELY_W-1:0]  vel_y;
		logic [VEL_W-1:0]   vel_z;
		logic [FALL_W-1:0]  fall;
		logic [DELAY_W-1:0] delay;
	} dot_entry_t;

	// Read request for one slot of a tick walk, with the slot's mode bits.
	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] idx;
		logic             live;
		logic             moving;
	} walk_req_t;

	// Outcome of one slot, from the stage-2 registers behind its request.
	typedef struct packed {
		logic             busy;
		logic             valid;
		logic [IDX_W-1:0] idx;
		logic             go;
		logic             hold;
		logic             in_box;
	} walk_res_t;

	// Values that stay fixed for the whole of one tick.
	typedef struct packed {
		logic              follow;
		logic [TIME_W-1:0] elapsed;
		logic [POS_W-1:0]  org_x;
		logic [POS_W-1:0]  org_y;
		logic [POS_W-1:0]  org_z;
	} tick_ctx_t;

	// Absolute box limits, origin plus offset at full precision.
	typedef struct packed {
		logic [LIM_W-1:0] x_lo;
		logic [LIM_W-1:0] x_hi;
		logic [LIM_W-1:0] y_lo;
		logic [LIM_W-1:0] y_hi;
		logic [LIM_W-1:0] z_lo;
		logic [LIM_W-1:0] z_hi;
	} limits_t;

endpackage

// File: hdl/pfu_dot_store.sv
// Slot memory and the two-stage read-modify-write datapath of a tick walk.
module pfu_dot_store (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load_we,
	input  logic [pfu_pkg::IDX_W-1:0] load_idx,
	input  pfu_pkg::dot_entry_t    load_entry,
	input  pfu_pkg::walk_req_t     req,
	input  pfu_pkg::tick_ctx_t     ctx,
	input  pfu_pkg::limits_t       lim,
	output pfu_pkg::walk_res_t     res
);
	import pfu_pkg::*;

	dot_entry_t dot_mem [MAX_DOTS];

	dot_entry_t       rd_s1;
	logic             valid_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             live_s1;
	logic             moving_s1;

	logic             valid_s2;
	logic [IDX_W-1:0] idx_s2;
	logic             go_s2;
	logic             hold_s2;
	logic [POS_W-1:0] px_s2;
	logic [POS_W-1:0] py_s2;
	logic [POS_W-1:0] pz_s2;

	logic             start;
	logic             hold;
	logic             go;
	logic [POS_W-1:0] base_x;
	logic [POS_W-1:0] base_y;
	logic [POS_W-1:0] base_z;
	dot_entry_t       wb;
	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;
	dot_entry_t       wr_data;

	logic signed [LIM_W-1:0] px;
	logic signed [LIM_W-1:0] py;
	logic signed [LIM_W-1:0] pz;
	logic                    out_x;
	logic                    out_y;
	logic                    out_z;

	// A waiting slot starts once its delay is reached; a starting slot moves in the same tick.
	always_comb begin
		start  = live_s1 && !moving_s1 && (TIME_W'(rd_s1.delay) <= ctx.elapsed);
		hold   = live_s1 && !moving_s1 && !start;
		go     = moving_s1 || start;
		base_x = (start && ctx.follow) ? ctx.org_x : rd_s1.pos_x;
		base_y = (start && ctx.follow) ? ctx.org_y : rd_s1.pos_y;
		base_z = (start && ctx.follow) ? ctx.org_z : rd_s1.pos_z;
		wb       = rd_s1;
		wb.pos_x = base_x + POS_W'($signed(rd_s1.vel_x));
		wb.pos_y = base_y + rd_s1.vel_y;
		wb.pos_z = base_z + POS_W'($signed(rd_s1.vel_z));
		wb.vel_y = rd_s1.vel_y - VELY_W'(rd_s1.fall);
	end

	// Loads only arrive while no walk is in flight, so the port is never contended.
	assign wr_en   = load_we || (valid_s1 && go);
	assign wr_idx  = load_we ? load_idx : idx_s1;
	assign wr_data = load_we ? load_entry : wb;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			dot_mem[wr_idx] <= wr_data;
		end
		if (req.valid) begin
			rd_s1 <= dot_mem[req.idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= req.valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1    <= req.idx;
		live_s1   <= req.live;
		moving_s1 <= req.moving;
		idx_s2    <= idx_s1;
		go_s2     <= go;
		hold_s2   <= hold;
		px_s2     <= wb.pos_x;
		py_s2     <= wb.pos_y;
		pz_s2     <= wb.pos_z;
	end

	always_comb begin
		px    = LIM_W'($signed(px_s2));
		py    = LIM_W'($signed(py_s2));
		pz    = LIM_W'($signed(pz_s2));
		out_x = (px < $signed(lim.x_lo)) || (px > $signed(lim.x_hi));
		out_y = (py < $signed(lim.y_lo)) || (py > $signed(lim.y_hi));
		out_z = (pz < $signed(lim.z_lo)) || (pz > $signed(lim.z_hi));
	end

	assign res.busy   = valid_s1 || valid_s2;
	assign res.valid  = valid_s2;
	assign res.idx    = idx_s2;
	assign res.go     = go_s2;
	assign res.hold   = hold_s2;
	assign res.in_box = !(out_x || out_y || out_z);

endmodule

// File: hdl/particle_flow_update_unit.sv
// Top level of the particle flow update unit: handshakes, configuration, mode bits, control.
//
// Channel   Direction  Handshake           Carries
// s_*       in         s_tvalid/s_tready   one load or tick item (action in s_tuser)
// m_*       out        m_tvalid/m_tready   flow_active and live_count, one per item
// cfg_*     in         cfg_we              box offsets, follow_origin, dots_in_use
//
// An accepted item passes the walk, drain and done states before its result enters the
// output register; the walk covers the n slots of the flow (at most 32). A tick that finds
// the flow stopped, or the owner gone, skips the walk and drain. A tick's walk reads one
// memory entry per cycle through the single read port of the slot memory.
// Reset clears the mode bits of every slot (all dead), the run flag and the configuration registers.
// A result waits in the output register while the next item is accepted; a stalled
// output only holds the block once the following result is ready.
module particle_flow_update_unit (
	input  logic         clk,
	input  logic         arst_n,
	// dot_index[4:0], origin_x[28:5], origin_y[52:29], origin_z[76:53], speed_x[92:77],
	// speed_y[108:93], speed_z[124:109], gravity[133:125], wait_ticks[143:134],
	// elapsed[159:144], owner_alive[160], zero fill[167:161]
	input  logic [167:0] s_tdata,
	// action[0]
	input  logic         s_tuser,
	input  logic         s_tvalid,
	output logic         s_tready,
	// flow_active[0], live_count[6:1], zero fill[7]
	output logic [7:0]   m_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	input  logic         cfg_we,
	input  logic [pfu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pfu_pkg::BOX_W-1:0]     cfg_data
);
	import pfu_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WALK  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	// Input fields.
	logic [SLOT_W-1:0]         dot_index;
	logic signed [POS_W-1:0]   origin_x;
	logic signed [POS_W-1:0]   origin_y;
	logic signed [POS_W-1:0]   origin_z;
	logic signed [VEL_W-1:0]   speed_x;
	logic signed [VEL_W-1:0]   speed_y;
	logic signed [VEL_W-1:0]   speed_z;
	logic [FALL_W-1:0]         gravity;
	logic [DELAY_W-1:0]        wait_ticks;
	logic [TIME_W-1:0]         elapsed;
	logic                      owner_alive;
	logic                      action;

	assign dot_index   = s_tdata[4:0];
	assign origin_x    = s_tdata[28:5];
	assign origin_y    = s_tdata[52:29];
	assign origin_z    = s_tdata[76:53];
	assign speed_x     = s_tdata[92:77];
	assign speed_y     = s_tdata[108:93];
	assign speed_z     = s_tdata[124:109];
	assign gravity     = s_tdata[133:125];
	assign wait_ticks  = s_tdata[143:134];
	assign elapsed     = s_tdata[159:144];
	assign owner_alive = s_tdata[160];
	assign action      = s_tuser;

	// Configuration registers.
	logic signed [BOX_W-1:0] box_x_low_q;
	logic signed [BOX_W-1:0] box_x_high_q;
	logic signed [BOX_W-1:0] box_y_low_q;
	logic signed [BOX_W-1:0] box_y_high_q;
	logic signed [BOX_W-1:0] box_z_low_q;
	logic signed [BOX_W-1:0] box_z_high_q;
	logic                    follow_q;
	logic [LIVE_W-1:0]       dots_in_use_q;

	// Control state.
	logic [1:0]          state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    live_cnt_q;
	logic                is_tick_q;
	logic                running_q;
	logic [MAX_DOTS-1:0] live_q;
	logic [MAX_DOTS-1:0] moving_q;
	tick_ctx_t           ctx_q;
	limits_t             lim_q;
	logic                out_valid_q;
	logic [LIVE_W-1:0]   out_live_q;

	logic             accept;
	logic             load_ok;
	logic             load_we;
	logic [IDX_W-1:0] load_idx;
	logic [IDX_W-1:0] cnt_idx;
	logic [CNT_W-1:0] n_slots;
	logic             walk_more;
	dot_entry_t       load_entry;
	walk_req_t        req;
	walk_res_t        res;
	logic             out_free;
	logic             out_load;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign load_ok  = (int'(dot_index) < MAX_DOTS);
	assign load_we  = accept && (action == ACT_LOAD) && load_ok;
	assign load_idx = IDX_W'(dot_index);
	assign cnt_idx  = cnt_q[IDX_W-1:0];
	assign out_free = !out_valid_q || m_tready;
	assign out_load = (state_q == ST_DONE) && out_free;

	// Slots 0 .. n-1 form the flow.
	assign n_slots   = (int'(dots_in_use_q) > MAX_DOTS) ? CNT_W'(MAX_DOTS)
	                                                     : CNT_W'(dots_in_use_q);
	assign walk_more = (state_q == ST_WALK) && (cnt_q != n_slots);

	// A loaded particle starts at the given origin; its y velocity is widened to 24 bits.
	always_comb begin
		load_entry.pos_x = origin_x;
		load_entry.pos_y = origin_y;
		load_entry.pos_z = origin_z;
		load_entry.vel_x = speed_x;
		load_entry.vel_y = VELY_W'(speed_y);
		load_entry.vel_z = speed_z;
		load_entry.fall  = gravity;
		load_entry.delay = wait_ticks;
	end

	// Only a tick reads the slot memory; a load just counts the mode bits.
	always_comb begin
		req.valid  = walk_more && is_tick_q;
		req.idx    = cnt_idx;
		req.live   = live_q[cnt_idx];
		req.moving = moving_q[cnt_idx];
	end

	pfu_dot_store u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_we    (load_we),
		.load_idx   (load_idx),
		.load_entry (load_entry),
		.req        (req),
		.ctx        (ctx_q),
		.lim        (lim_q),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_x_low_q   <= '0;
			box_x_high_q  <= '0;
			box_y_low_q   <= '0;
			box_y_high_q  <= '0;
			box_z_low_q   <= '0;
			box_z_high_q  <= '0;
			follow_q      <= 1'b0;
			dots_in_use_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BOX_X_LOW:  box_x_low_q   <= cfg_data;
				REG_BOX_X_HIGH: box_x_high_q  <= cfg_data;
				REG_BOX_Y_LOW:  box_y_low_q   <= cfg_data;
				REG_BOX_Y_HIGH: box_y_high_q  <= cfg_data;
				REG_BOX_Z_LOW:  box_z_low_q   <= cfg_data;
				REG_BOX_Z_HIGH: box_z_high_q  <= cfg_data;
				REG_FOLLOW:     follow_q      <= cfg_data[0];
				REG_DOTS:       dots_in_use_q <= cfg_data[LIVE_W-1:0];
				default: ;
			endcase
		end
	end

	// Per-item values, fixed for the whole walk. The box limits are taken at full
	// precision, so the comparison never wraps.
	always_ff @(posedge clk) begin
		if (accept) begin
			ctx_q.follow  <= follow_q;
			ctx_q.elapsed <= elapsed;
			ctx_q.org_x   <= origin_x;
			ctx_q.org_y   <= origin_y;
			ctx_q.org_z   <= origin_z;
			lim_q.x_lo    <= LIM_W'(origin_x) + LIM_W'(box_x_low_q);
			lim_q.x_hi    <= LIM_W'(origin_x) + LIM_W'(box_x_high_q);
			lim_q.y_lo    <= LIM_W'(origin_y) + LIM_W'(box_y_low_q);
			lim_q.y_hi    <= LIM_W'(origin_y) + LIM_W'(box_y_high_q);
			lim_q.z_lo    <= LIM_W'(origin_z) + LIM_W'(box_z_low_q);
			lim_q.z_hi    <= LIM_W'(origin_z) + LIM_W'(box_z_high_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			live_cnt_q  <= '0;
			is_tick_q   <= 1'b0;
			running_q   <= 1'b0;
			live_q      <= '0;
			moving_q    <= '0;
			out_valid_q <= 1'b0;
			out_live_q  <= '0;
		end else begin
			// The output register takes a new result or empties when its result is taken.
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_live_q  <= LIVE_W'(live_cnt_q);
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						is_tick_q  <= action;
						cnt_q      <= '0;
						live_cnt_q <= '0;
						if (action == ACT_LOAD) begin
							// A load restarts the flow and puts its slot in the waiting mode.
							running_q <= 1'b1;
							if (load_ok) begin
								live_q[load_idx]   <= 1'b1;
								moving_q[load_idx] <= 1'b0;
							end
							state_q <= ST_WALK;
						end else if (!running_q) begin
							state_q <= ST_DONE;
						end else if (follow_q && !owner_alive) begin
							// The owner is gone: the whole flow dies at once.
							live_q    <= '0;
							moving_q  <= '0;
							running_q <= 1'b0;
							state_q   <= ST_DONE;
						end else begin
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (walk_more) begin
						cnt_q <= cnt_q + 1'b1;
						if (!is_tick_q && live_q[cnt_idx]) begin
							live_cnt_q <= live_cnt_q + 1'b1;
						end
					end else begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!res.busy) begin
						// A tick that leaves nothing alive stops the flow.
						if (is_tick_q && (live_cnt_q == '0)) begin
							live_q    <= '0;
							moving_q  <= '0;
							running_q <= 1'b0;
						end
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// Mode update of one slot at the end of its read-modify-write.
			if (res.valid) begin
				if (res.go) begin
					live_q[res.idx]   <= res.in_box;
					moving_q[res.idx] <= res.in_box;
				end else if (!res.hold) begin
					live_q[res.idx]   <= 1'b0;
					moving_q[res.idx] <= 1'b0;
				end
				if (res.hold || (res.go && res.in_box)) begin
					live_cnt_q <= live_cnt_q + 1'b1;
				end
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_live_q, (out_live_q != '0)};

endmodule

// File: hdl/pfu_checker.sv
// Port-level checks of the particle flow update unit, bound to the top level.
module pfu_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [7:0]   m_tdata,
	input logic         m_tvalid,
	input logic         m_tready
);
	import pfu_pkg::*;

	// A held result keeps its value until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// The active flag agrees with the count.
	a_active_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] == (m_tdata[6:1] != 6'd0)))
		else $error("flow_active disagrees with live_count");

	// The count never exceeds the number of slots.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (int'(m_tdata[6:1]) <= MAX_DOTS) && !m_tdata[7])
		else $error("live_count out of range");

	// One item is worked on at a time: input closes right after an acceptance.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item accepted while busy");

endmodule

bind particle_flow_update_unit pfu_checker u_pfu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tdata  (m_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready)
);

// File: tb/particle_flow_update_unit_test.sv
`timescale 1ns / 100ps
// Self-checking testbench of the particle flow update unit, with its own flow predictor.
module particle_flow_update_unit_test;
	import pfu_pkg::*;

	// The watchdog gives up after this many cycles without any accepted item or result. The
	// longest legal quiet stretch is the output hold-off below plus one item's walk and a gap.
	localparam int IDLE_LIMIT   = 3000;
	localparam int HOLD_CYCLES  = 400;
	// This covers a tick over a full flow at the end of the run.
	localparam int DRAIN_CYCLES = 40;

	localparam logic [POS_W-1:0] POS_MAX = 24'h7FFFFF;
	localparam logic [POS_W-1:0] POS_MIN = 24'h800000;
	localparam logic [VEL_W-1:0] SPD_MAX = 16'h7FFF;
	localparam logic [VEL_W-1:0] SPD_MIN = 16'h8000;
	localparam logic [BOX_W-1:0] BOX_MAX = 16'h7FFF;
	localparam logic [BOX_W-1:0] BOX_MIN = 16'h8000;

	typedef enum logic [1:0] {
		DOT_DEAD = 2'd0,
		DOT_WAIT = 2'd1,
		DOT_MOVE = 2'd2
	} dot_mode_e;

	// One input item, in the order of the fields on s_tdata.
	typedef struct packed {
		logic               action;
		logic [SLOT_W-1:0]  slot;
		logic [POS_W-1:0]   org_x;
		logic [POS_W-1:0]   org_y;
		logic [POS_W-1:0]   org_z;
		logic [VEL_W-1:0]   spd_x;
		logic [VEL_W-1:0]   spd_y;
		logic [VEL_W-1:0]   spd_z;
		logic [FALL_W-1:0]  grav;
		logic [DELAY_W-1:0] wait_t;
		logic [TIME_W-1:0]  elapsed;
		logic               owner;
	} dot_item_t;

	typedef struct packed {
		logic              active;
		logic [LIVE_W-1:0] live;
	} flow_res_t;

	typedef struct packed {
		logic [BOX_W-1:0]  x_lo;
		logic [BOX_W-1:0]  x_hi;
		logic [BOX_W-1:0]  y_lo;
		logic [BOX_W-1:0]  y_hi;
		logic [BOX_W-1:0]  z_lo;
		logic [BOX_W-1:0]  z_hi;
		logic              follow;
		logic [LIVE_W-1:0] dots;
	} flow_cfg_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic [167:0]         s_tdata   = '0;
	logic                 s_tuser   = ACT_LOAD;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [7:0]           m_tdata;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_BOX_X_LOW;
	logic [BOX_W-1:0]     cfg_data  = '0;

	// Expected results in order of acceptance, and the bookkeeping around them.
	flow_res_t flow_expect [$];
	int        errors      = 0;
	int        items_sent  = 0;
	int        idle_cycles = 0;

	// Idling controls: percentages of cycles that start a burst of idle cycles.
	int   tx_gap_pct   = 0;
	int   rx_gap_pct   = 0;
	int   rx_gap_left  = 0;
	int   rx_hold_left = 0;
	logic rx_hold_req  = 1'b0;

	// Predictor copy of the configuration registers.
	logic [BOX_W-1:0]  lim_x_lo = '0, lim_x_hi = '0;
	logic [BOX_W-1:0]  lim_y_lo = '0, lim_y_hi = '0;
	logic [BOX_W-1:0]  lim_z_lo = '0, lim_z_hi = '0;
	logic              follow_org = 1'b0;
	logic [LIVE_W-1:0] flow_slots = '0;

	// Predictor copy of the particle store and the run flag.
	logic [POS_W-1:0]   dot_px    [MAX_DOTS];
	logic [POS_W-1:0]   dot_py    [MAX_DOTS];
	logic [POS_W-1:0]   dot_pz    [MAX_DOTS];
	logic [VEL_W-1:0]   dot_vx    [MAX_DOTS];
	logic [VELY_W-1:0]  dot_vy    [MAX_DOTS];
	logic [VEL_W-1:0]   dot_vz    [MAX_DOTS];
	logic [FALL_W-1:0]  dot_fall  [MAX_DOTS];
	logic [DELAY_W-1:0] dot_delay [MAX_DOTS];
	dot_mode_e          dot_mode  [MAX_DOTS];
	logic               flow_on;

	flow_res_t seen, want;

	particle_flow_update_unit i_dut (.*);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------
	// Flow predictor
	// ------------------------------------------------------------------

	function automatic void kill_flow();
		int i;
		for (i = 0; i < MAX_DOTS; i++) begin
			dot_mode[i] = DOT_DEAD;
		end
		flow_on = 1'b0;
	endfunction

	// The box limits are origin plus offset at full precision, so nothing wraps here.
	function automatic logic outside_box(logic [POS_W-1:0] p, logic [POS_W-1:0] org,
			logic [BOX_W-1:0] lo, logic [BOX_W-1:0] hi);
		longint v, o;
		v = longint'($signed(p));
		o = longint'($signed(org));
		return (v < o + longint'($signed(lo))) || (v > o + longint'($signed(hi)));
	endfunction

	// Applies one accepted item to the predicted store and returns the result it causes.
	function automatic flow_res_t advance_flow(dot_item_t it);
		int        n, live, i;
		dot_mode_e m;
		flow_res_t r;
		n    = (flow_slots > MAX_DOTS) ? MAX_DOTS : int'(flow_slots);
		live = 0;
		if (it.action == ACT_LOAD) begin
			// A load always restarts the flow, even when its slot lies beyond the flow.
			dot_px[it.slot]    = it.org_x;
			dot_py[it.slot]    = it.org_y;
			dot_pz[it.slot]    = it.org_z;
			dot_vx[it.slot]    = it.spd_x;
			dot_vy[it.slot]    = {{(VELY_W - VEL_W){it.spd_y[VEL_W-1]}}, it.spd_y};
			dot_vz[it.slot]    = it.spd_z;
			dot_fall[it.slot]  = it.grav;
			dot_delay[it.slot] = it.wait_t;
			dot_mode[it.slot]  = DOT_WAIT;
			flow_on = 1'b1;
			for (i = 0; i < n; i++) begin
				if (dot_mode[i] != DOT_DEAD) begin
					live++;
				end
			end
		end else if (flow_on) begin
			if (follow_org && !it.owner) begin
				// The owner is gone while the origin is followed: the whole flow stops.
				kill_flow();
			end else begin
				for (i = 0; i < n; i++) begin
					m = dot_mode[i];
					if (m == DOT_WAIT && dot_delay[i] <= it.elapsed) begin
						m = DOT_MOVE;
						if (follow_org) begin
							dot_px[i] = it.org_x;
							dot_py[i] = it.org_y;
							dot_pz[i] = it.org_z;
						end
					end
					if (m == DOT_WAIT) begin
						live++;
					end else if (m == DOT_MOVE) begin
						dot_px[i] = dot_px[i] + {{(POS_W - VEL_W){dot_vx[i][VEL_W-1]}}, dot_vx[i]};
						dot_py[i] = dot_py[i] + dot_vy[i];
						dot_pz[i] = dot_pz[i] + {{(POS_W - VEL_W){dot_vz[i][VEL_W-1]}}, dot_vz[i]};
						dot_vy[i] = dot_vy[i] - {{(VELY_W - FALL_W){1'b0}}, dot_fall[i]};
						if (outside_box(dot_px[i], it.org_x, lim_x_lo, lim_x_hi) ||
						    outside_box(dot_py[i], it.org_y, lim_y_lo, lim_y_hi) ||
						    outside_box(dot_pz[i], it.org_z, lim_z_lo, lim_z_hi)) begin
							m = DOT_DEAD;
						end else begin
							live++;
						end
					end else begin
						m = DOT_DEAD;
					end
					dot_mode[i] = m;
				end
				// An empty flow stops, and that clears slots beyond the flow as well.
				if (live == 0) begin
					kill_flow();
				end
			end
		end
		if (!flow_on) begin
			live = 0;
		end
		r.active = (live != 0);
		r.live   = LIVE_W'(live);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Item and configuration builders
	// ------------------------------------------------------------------

	// Every field random over its full width; builders below start from this so that
	// the fields an item does not use still toggle.
	function automatic dot_item_t random_item();
		logic [191:0] bits;
		bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		return dot_item_t'(bits[$bits(dot_item_t)-1:0]);
	endfunction

	function automatic dot_item_t load_item(logic [SLOT_W-1:0] slot,
			logic [POS_W-1:0] ox, logic [POS_W-1:0] oy, logic [POS_W-1:0] oz,
			logic [VEL_W-1:0] sx, logic [VEL_W-1:0] sy, logic [VEL_W-1:0] sz,
			logic [FALL_W-1:0] grav, logic [DELAY_W-1:0] wt);
		dot_item_t it;
		it        = random_item();
		it.action = ACT_LOAD;
		it.slot   = slot;
		it.org_x  = ox;
		it.org_y  = oy;
		it.org_z  = oz;
		it.spd_x  = sx;
		it.spd_y  = sy;
		it.spd_z  = sz;
		it.grav   = grav;
		it.wait_t = wt;
		return it;
	endfunction

	function automatic dot_item_t tick_item(logic [TIME_W-1:0] el, logic [POS_W-1:0] ox,
			logic [POS_W-1:0] oy, logic [POS_W-1:0] oz, logic owner);
		dot_item_t it;
		it         = random_item();
		it.action  = ACT_TICK;
		it.elapsed = el;
		it.org_x   = ox;
		it.org_y   = oy;
		it.org_z   = oz;
		it.owner   = owner;
		return it;
	endfunction

	function automatic logic [VEL_W-1:0] rand_speed(int mag);
		return 16'(int'($urandom_range(0, 2 * mag)) - mag);
	endfunction

	function automatic flow_cfg_t box_cfg(logic [BOX_W-1:0] lo, logic [BOX_W-1:0] hi,
			logic follow, logic [LIVE_W-1:0] dots);
		return '{x_lo: lo, x_hi: hi, y_lo: lo, y_hi: hi, z_lo: lo, z_hi: hi,
			follow: follow, dots: dots};
	endfunction

	// Mostly wide boxes so that particles live for a while; sometimes fully random
	// (possibly inverted) limits, the extremes, or a tight box.
	function automatic flow_cfg_t random_cfg();
		flow_cfg_t        c;
		logic [BOX_W-1:0] lims [6];
		int               style, a;
		style = $urandom_range(0, 6);
		for (a = 0; a < 6; a++) begin
			if (style == 0) begin
				lims[a] = 16'($urandom);
			end else if (style == 1) begin
				lims[a] = a[0] ? BOX_MAX : BOX_MIN;
			end else if (style == 2) begin
				lims[a] = a[0] ? 16'($urandom_range(0, 300)) : 16'(-int'($urandom_range(0, 300)));
			end else begin
				lims[a] = a[0] ? 16'($urandom_range(200, 32767))
					: 16'(-int'($urandom_range(200, 32768)));
			end
		end
		c.x_lo   = lims[0];
		c.x_hi   = lims[1];
		c.y_lo   = lims[2];
		c.y_hi   = lims[3];
		c.z_lo   = lims[4];
		c.z_hi   = lims[5];
		c.follow = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 9))
			0: begin
				c.dots = 6'd0;
			end
			1: begin
				c.dots = 6'd32;
			end
			2: begin
				c.dots = 6'd1;
			end
			default: begin
				c.dots = 6'($urandom_range(2, 31));
			end
		endcase
		return c;
	endfunction

	function automatic int gap_pct();
		case ($urandom_range(0, 2))
			0: begin
				return 0;
			end
			1: begin
				return 15;
			end
			default: begin
				return 50;
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// Offers one item and waits for its handshake. Valid stays high afterwards so that
	// the next item can follow back to back; it is lowered only by a gap or a drain.
	task automatic send_item(dot_item_t it);
		if ($urandom_range(0, 99) < tx_gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_tdata  <= {7'd0, it.owner, it.elapsed, it.wait_t, it.grav, it.spd_z, it.spd_y,
			it.spd_x, it.org_z, it.org_y, it.org_x, it.slot};
		s_tuser  <= it.action;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		flow_expect.push_back(advance_flow(it));
		items_sent++;
	endtask

	// Stops offering items and waits until every expected result has come back.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (flow_expect.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BOX_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_BOX_X_LOW: begin
				lim_x_lo = val;
			end
			REG_BOX_X_HIGH: begin
				lim_x_hi = val;
			end
			REG_BOX_Y_LOW: begin
				lim_y_lo = val;
			end
			REG_BOX_Y_HIGH: begin
				lim_y_hi = val;
			end
			REG_BOX_Z_LOW: begin
				lim_z_lo = val;
			end
			REG_BOX_Z_HIGH: begin
				lim_z_hi = val;
			end
			REG_FOLLOW: begin
				follow_org = val[0];
			end
			REG_DOTS: begin
				flow_slots = val[LIVE_W-1:0];
			end
			default: begin
			end
		endcase
	endtask

	// Writes every register back to back; only called while the block is idle.
	task automatic program_flow(flow_cfg_t c);
		write_reg(REG_BOX_X_LOW, c.x_lo);
		write_reg(REG_BOX_X_HIGH, c.x_hi);
		write_reg(REG_BOX_Y_LOW, c.y_lo);
		write_reg(REG_BOX_Y_HIGH, c.y_hi);
		write_reg(REG_BOX_Z_LOW, c.z_lo);
		write_reg(REG_BOX_Z_HIGH, c.z_hi);
		write_reg(REG_FOLLOW, 16'(c.follow));
		write_reg(REG_DOTS, 16'(c.dots));
		cfg_we <= 1'b0;
	endtask

	// A well-formed flow: loads into the flow's slots around one origin, then ticks with
	// a rising elapsed time. A few loads land mid-run, a few ticks move the origin, and a
	// small share of items is pure noise.
	task automatic run_flow_sequence(int loads, int ticks);
		dot_item_t         it;
		logic [POS_W-1:0]  ox, oy, oz;
		logic [TIME_W-1:0] el;
		logic [SLOT_W-1:0] slot;
		logic              owner;
		int                mag, n, k;
		ox = 24'($urandom);
		oy = 24'($urandom);
		oz = 24'($urandom);
		el = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 900));
		case ($urandom_range(0, 7))
			0: begin
				mag = 32767;
			end
			1, 2: begin
				mag = 8;
			end
			3, 4: begin
				mag = 400;
			end
			default: begin
				mag = 60;
			end
		endcase
		n = (flow_slots > MAX_DOTS) ? MAX_DOTS : int'(flow_slots);
		for (k = 0; k < loads + ticks; k++) begin
			if ($urandom_range(0, 99) < 5) begin
				it = random_item();
			end else if (k < loads || $urandom_range(0, 99) < 4) begin
				slot = (n != 0 && $urandom_range(0, 7) != 0) ? 5'($urandom_range(0, n - 1))
					: 5'($urandom);
				it = load_item(slot, ox, oy, oz, rand_speed(mag), rand_speed(mag),
					rand_speed(mag),
					($urandom_range(0, 7) == 0) ? 9'($urandom) : 9'($urandom_range(0, 12)),
					(el < 1000) ? 10'(el + $urandom_range(0, 12)) : 10'($urandom));
			end else begin
				owner = follow_org ? ($urandom_range(0, 39) != 0) : 1'($urandom);
				if ($urandom_range(0, 9) == 0) begin
					it = tick_item(el, ox + 24'($signed(rand_speed(64))), oy, oz, owner);
				end else begin
					it = tick_item(el, ox, oy, oz, owner);
				end
				el = el + 16'($urandom_range(0, 3));
			end
			send_item(it);
		end
	endtask

	// ------------------------------------------------------------------
	// Receiver, result checker and watchdog
	// ------------------------------------------------------------------

	// The receiver stalls in random bursts, and for one long stretch on request.
	always @(posedge clk) begin
		if (rx_hold_req) begin
			rx_hold_req  = 1'b0;
			rx_hold_left = HOLD_CYCLES;
		end
		if (rx_hold_left != 0) begin
			rx_hold_left--;
			m_tready <= 1'b0;
		end else if (rx_gap_left != 0) begin
			rx_gap_left--;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 99) < rx_gap_pct) begin
			rx_gap_left = $urandom_range(0, 7);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Every accepted result is matched against the oldest expectation.
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			seen = {m_tdata[0], m_tdata[LIVE_W:1]};
			if (flow_expect.size() == 0) begin
				errors++;
				$error("result with nothing expected: flow_active %0d, live_count %0d",
					seen.active, seen.live);
			end else begin
				want = flow_expect.pop_front();
				if (seen.active !== want.active) begin
					errors++;
					$error("flow_active: expected %0d, actual %0d", want.active, seen.active);
				end
				if (seen.live !== want.live) begin
					errors++;
					$error("live_count: expected %0d, actual %0d", want.live, seen.live);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("particle_flow_update_unit_test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	task automatic test_directed_cases();
		tx_gap_pct = 15;
		rx_gap_pct = 15;
		// Widest box, four slots in the flow.
		program_flow(box_cfg(BOX_MIN, BOX_MAX, 1'b0, 6'd4));
		// A tick straight after reset finds the flow stopped.
		send_item(tick_item(16'd0, '0, '0, '0, 1'b1));
		// A particle at rest on the origin, then a slot beyond the flow with every
		// field at its maximum.
		send_item(load_item(5'd0, '0, '0, '0, '0, '0, '0, 9'd0, 10'd0));
		send_item(load_item(5'd31, POS_MAX, POS_MAX, POS_MAX, SPD_MAX, SPD_MAX, SPD_MAX,
			9'd511, 10'd1023));
		// This one starts on the first tick and its position wraps past the top.
		send_item(load_item(5'd1, POS_MAX, POS_MAX, POS_MAX, SPD_MAX, SPD_MAX, SPD_MAX,
			9'd0, 10'd0));
		send_item(load_item(5'd2, POS_MIN, POS_MIN, POS_MIN, SPD_MIN, SPD_MIN, SPD_MIN,
			9'd511, 10'd1023));
		// Heavy fall rate, starting exactly when elapsed reaches the delay.
		send_item(load_item(5'd3, '0, '0, '0, '0, 16'd100, '0, 9'd511, 10'd2));
		send_item(tick_item(16'd0, '0, '0, '0, 1'b1));
		send_item(tick_item(16'd1, '0, '0, '0, 1'b1));
		send_item(tick_item(16'd2, '0, '0, '0, 1'b1));
		// Largest elapsed time at the corners of the origin range; owner_alive is
		// ignored while the origin is not followed.
		send_item(tick_item(16'hFFFF, POS_MIN, POS_MAX, '0, 1'b0));
		send_item(tick_item(16'hFFFF, POS_MAX, POS_MIN, POS_MAX, 1'b0));
		wait_drained();

		// Zero-sized box, origin followed, every slot in the flow.
		program_flow(box_cfg('0, '0, 1'b1, 6'd32));
		send_item(load_item(5'd5, 24'd100, 24'(-200), 24'd300, '0, '0, '0, 9'd0, 10'd5));
		send_item(tick_item(16'd5, 24'd1, 24'd2, 24'd3, 1'b1));
		send_item(tick_item(16'd6, 24'd1, 24'd2, 24'd3, 1'b1));
		// The owner goes away, and the next tick finds the flow stopped.
		send_item(tick_item(16'd7, 24'd1, 24'd2, 24'd3, 1'b0));
		send_item(tick_item(16'd8, 24'd1, 24'd2, 24'd3, 1'b1));
		wait_drained();

		// An empty flow: the load restarts it, the tick finds nothing live and stops it.
		program_flow(box_cfg(BOX_MIN, BOX_MAX, 1'b0, 6'd0));
		send_item(load_item(5'd7, '0, '0, '0, 16'd1, 16'd1, 16'd1, 9'd1, 10'd0));
		send_item(tick_item(16'd0, '0, '0, '0, 1'b1));
		wait_drained();
	endtask

	// Random phases, each with its own registers and idling, until the item budget is used.
	task automatic test_random_flows();
		while (items_sent < 860) begin
			tx_gap_pct = gap_pct();
			rx_gap_pct = gap_pct();
			program_flow(random_cfg());
			run_flow_sequence($urandom_range(1, flow_slots + 3), $urandom_range(4, 40));
			wait_drained();
		end
	endtask

	// The receiver holds off long enough for the block to fill and stall its input,
	// while items keep coming; then the sender pauses until everything is back.
	task automatic test_output_stall();
		tx_gap_pct = 0;
		rx_gap_pct = 10;
		program_flow(box_cfg(BOX_MIN, BOX_MAX, 1'b0, 6'd32));
		rx_hold_req = 1'b1;
		run_flow_sequence(20, 12);
		wait_drained();
		run_flow_sequence(4, 10);
		wait_drained();
	endtask

	// The closing stretch runs without any idling on either side.
	task automatic test_steady_stream();
		tx_gap_pct = 0;
		rx_gap_pct = 0;
		program_flow(random_cfg());
		run_flow_sequence($urandom_range(1, flow_slots + 3), 40);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		kill_flow();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_random_flows();
		test_output_stall();
		test_steady_stream();
		if (errors == 0) begin
			$display("particle_flow_update_unit_test passed");
		end else begin
			$display("particle_flow_update_unit_test failed");
		end
		$finish;
	end

endmodule
